// ===== hw/rtl/cov2x2_eigen_floor_core_assert.svh =====
// Assertion macros shared by the RTL of the eigen floor core.
`ifndef COV2X2_EIGEN_FLOOR_CORE_ASSERT_SVH
`define COV2X2_EIGEN_FLOOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define CEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cef_pkg.sv =====
package cef_pkg;

    localparam int ANGLE_STEPS = 18;

    localparam int MW = 33;          // magnitude of a difference or sum
    localparam int QW = 35;          // square root result
    localparam int NW = 2 * QW;      // square root operand
    localparam int RW = 31;          // ratio |a|/q, |b|/q
    localparam int CW = 56;          // vectoring x, y
    localparam int ZW = 34;          // angle accumulator, Q3.30
    localparam int AW = 19;          // angle output, Q2.16
    localparam int EW = 38;          // eigenvalue arithmetic
    localparam int DW = 36;          // eigenvalue spread
    localparam int LW = DW / 2;      // spread split for partial products
    localparam int PW = DW + RW;     // full product
    localparam int CORDIC_SHIFT = 20;

    // Stage indexes of the pipeline; stage 0 is the input register.
    localparam int S_N    = 2;
    localparam int S_Q    = S_N + QW;
    localparam int S_D    = S_Q + RW;
    localparam int S_ANG  = ANGLE_STEPS + 2;
    localparam int LAST   = S_D + 4;

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam int ANG_MAX = 262143;
    localparam int ANG_MIN = -131072;

    localparam logic REG_FLOOR = 1'b0;

    typedef struct packed {
        logic signed [MW-1:0] s;
        logic [MW-1:0]        ma;
        logic [MW-1:0]        mb;
        logic                 sa;
        logic                 sb;
    } t_pre;

    typedef struct packed {
        logic signed [MW-1:0] s;
        logic signed [EW-1:0] big;
        logic signed [EW-1:0] small_v;
        logic signed [EW-1:0] bigf;
        logic signed [EW-1:0] smallf;
        logic [DW-1:0]        d;
        logic signed [EW:0]   sum;
        logic                 sa;
        logic                 sb;
        logic                 qz;
    } t_eig;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            5'd31: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cef_root.sv =====
module cef_root import cef_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_n,
    output logic [QW-1:0] o_root
);

    logic [QW+1:0] r_rem  [QW];
    logic [QW-1:0] r_root [QW];
    logic [NW-1:0] r_rest [QW];
    logic [QW+1:0] n_rem  [QW];
    logic [QW-1:0] n_root [QW];
    logic [NW-1:0] n_rest [QW];

    // One result bit per stage, two operand bits consumed per stage.
    always_comb begin : root_steps
        logic [QW+1:0] prem;
        logic [QW-1:0] proot;
        logic [NW-1:0] prest;
        logic [QW+1:0] rem_sh;
        logic [QW+1:0] trial;
        logic          ge;
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                prem  = '0;
                proot = '0;
                prest = i_n;
            end else begin
                prem  = r_rem[j-1];
                proot = r_root[j-1];
                prest = r_rest[j-1];
            end
            rem_sh    = {prem[QW-1:0], prest[NW-1:NW-2]};
            trial     = {proot, 2'b01};
            ge        = (rem_sh >= trial);
            n_rem[j]  = ge ? (rem_sh - trial) : rem_sh;
            n_root[j] = {proot[QW-2:0], ge};
            n_rest[j] = {prest[NW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rest <= n_rest;
        end
    end

    assign o_root = r_root[QW-1];

endmodule

// ===== hw/rtl/cef_div.sv =====
module cef_div import cef_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [QW-1:0] i_num,
    input  logic [QW-1:0] i_den,
    output logic [RW-1:0] o_quo
);

    logic [QW-1:0] r_rem [RW];
    logic [QW-1:0] r_den [RW];
    logic [RW-1:0] r_quo [RW];
    logic [QW-1:0] n_rem [RW];
    logic [QW-1:0] n_den [RW];
    logic [RW-1:0] n_quo [RW];

    // Numerator is below the divisor, so every quotient bit is fractional.
    always_comb begin : div_steps
        logic [QW-1:0] prem;
        logic [QW-1:0] pden;
        logic [RW-1:0] pquo;
        logic [QW:0]   rem_sh;
        logic [QW:0]   diff;
        logic          ge;
        for (int j = 0; j < RW; j++) begin
            if (j == 0) begin
                prem = i_num;
                pden = i_den;
                pquo = '0;
            end else begin
                prem = r_rem[j-1];
                pden = r_den[j-1];
                pquo = r_quo[j-1];
            end
            rem_sh   = {prem, 1'b0};
            ge       = (rem_sh >= {1'b0, pden});
            diff     = rem_sh - {1'b0, pden};
            n_rem[j] = ge ? diff[QW-1:0] : rem_sh[QW-1:0];
            n_den[j] = pden;
            n_quo[j] = {pquo[RW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo[RW-1];

endmodule

// ===== hw/rtl/cov2x2_eigen_floor_core.sv =====
// Channel  Handshake                    Beat contents
// -------  ---------------------------  --------------------------------------
// in       i_in_valid / o_in_stall      i_m00 i_m01 i_m10 i_m11
// out      o_out_valid / i_out_stall    o_eig_large o_eig_small o_axis_angle
//                                       o_floored_xx o_floored_xy o_floored_yy
// cfg      APB psel/penable/pwrite      eigen_floor at byte address 0
//
// One beat per cycle sustained while the output is not stalled.
// The 35-stage square root is followed by the 31-stage divider.
// Reset clears the valid bits of every stage and the floor register.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`include "cov2x2_eigen_floor_core_assert.svh"

module cov2x2_eigen_floor_core import cef_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_m00,
    input  logic signed [31:0] i_m01,
    input  logic signed [31:0] i_m10,
    input  logic signed [31:0] i_m11,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_eig_large,
    output logic signed [31:0] o_eig_small,
    output logic signed [18:0] o_axis_angle,
    output logic signed [31:0] o_floored_xx,
    output logic signed [31:0] o_floored_xy,
    output logic signed [31:0] o_floored_yy,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic              en;
    logic [LAST:0]     r_v;
    logic [30:0]       r_floor;

    assign en          = !(r_v[LAST] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_v[LAST];

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FLOOR) ? {1'b0, r_floor} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_FLOOR) begin
            r_floor <= pwdata[30:0];
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAST-1:0], i_in_valid};
        end
    end

    // ---------------- stage 0: differences ----------------
    logic signed [MW-1:0] w_a, w_b, w_s;
    logic signed [MW-1:0] r_a0, r_b0;
    t_pre                 r_pre [S_Q+1];
    t_pre                 n_pre0;

    assign w_a = MW'(i_m11) - MW'(i_m00);
    assign w_b = MW'(i_m01) + MW'(i_m10);
    assign w_s = MW'(i_m00) + MW'(i_m11);

    always_comb begin
        n_pre0.s  = w_s;
        n_pre0.ma = w_a[MW-1] ? MW'(-w_a) : MW'(w_a);
        n_pre0.mb = w_b[MW-1] ? MW'(-w_b) : MW'(w_b);
        n_pre0.sa = w_a[MW-1];
        n_pre0.sb = w_b[MW-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0     <= w_a;
            r_b0     <= w_b;
            r_pre[0] <= n_pre0;
            for (int k = 1; k <= S_Q; k++) begin
                r_pre[k] <= r_pre[k-1];
            end
        end
    end

    // ---------------- squares and root ----------------
    logic [2*MW-1:0] r_sqa, r_sqb;
    logic [NW-1:0]   r_n;
    logic [QW-1:0]   w_q2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqa <= r_pre[0].ma * r_pre[0].ma;
            r_sqb <= r_pre[0].mb * r_pre[0].mb;
            r_n   <= NW'({(2*MW+1)'(r_sqa) + (2*MW+1)'(r_sqb), 2'b00});
        end
    end

    cef_root u_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (r_n),
        .o_root (w_q2)
    );

    // ---------------- ratios ----------------
    logic [RW-1:0] w_ra, w_rb;

    cef_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (QW'(r_pre[S_Q].ma)),
        .i_den (w_q2),
        .o_quo (w_ra)
    );

    cef_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (QW'(r_pre[S_Q].mb)),
        .i_den (w_q2),
        .o_quo (w_rb)
    );

    // ---------------- eigenvalues ----------------
    t_eig                 r_eig [S_Q+1:LAST-1];
    t_eig                 n_eig [S_Q+1:LAST-1];
    logic signed [EW+1:0] w_bsum;
    logic signed [EW-1:0] w_fl;

    assign w_bsum = ((EW+2)'(r_pre[S_Q].s) <<< 1) + (EW+2)'($signed({1'b0, w_q2}))
                  + (EW+2)'(2);
    assign w_fl   = EW'($signed({1'b0, r_floor}));

    always_comb begin
        for (int k = S_Q + 1; k <= LAST - 1; k++) begin
            if (k == S_Q + 1) begin
                n_eig[k]         = '0;
                n_eig[k].s       = r_pre[S_Q].s;
                n_eig[k].big     = EW'(w_bsum >>> 2);
                n_eig[k].sa      = r_pre[S_Q].sa;
                n_eig[k].sb      = r_pre[S_Q].sb;
                n_eig[k].qz      = (w_q2 == '0);
            end else begin
                n_eig[k] = r_eig[k-1];
                if (k == S_Q + 2) begin
                    n_eig[k].small_v = EW'(r_eig[k-1].s) - r_eig[k-1].big;
                end
                if (k == S_Q + 3) begin
                    n_eig[k].bigf   = (r_eig[k-1].big > w_fl) ? r_eig[k-1].big : w_fl;
                    n_eig[k].smallf = (r_eig[k-1].small_v > w_fl) ? r_eig[k-1].small_v
                                                                  : w_fl;
                end
                if (k == S_Q + 4) begin
                    n_eig[k].d   = DW'(r_eig[k-1].bigf - r_eig[k-1].smallf);
                    n_eig[k].sum = (EW+1)'(r_eig[k-1].bigf) + (EW+1)'(r_eig[k-1].smallf);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eig <= n_eig;
        end
    end

    // ---------------- rebuild terms ----------------
    logic [LW+RW-1:0]     r_pal, r_pah, r_pbl, r_pbh;
    logic [PW-1:0]        r_pa, r_pb;
    logic signed [EW-1:0] r_ta, r_tb;
    logic [PW-1:0]        w_pa_r, w_pb_r;
    logic signed [EW-1:0] w_ta_m, w_tb_m;

    assign w_pa_r = r_pa + (PW'(1) << 29);
    assign w_pb_r = r_pb + (PW'(1) << 29);
    assign w_ta_m = EW'(w_pa_r >> 30);
    assign w_tb_m = EW'(w_pb_r >> 30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pal <= r_eig[S_D].d[LW-1:0] * w_ra;
            r_pah <= r_eig[S_D].d[DW-1:LW] * w_ra;
            r_pbl <= r_eig[S_D].d[LW-1:0] * w_rb;
            r_pbh <= r_eig[S_D].d[DW-1:LW] * w_rb;
            r_pa  <= PW'(r_pal) + (PW'(r_pah) << LW);
            r_pb  <= PW'(r_pbl) + (PW'(r_pbh) << LW);
            // drop the terms when the matrix has no anisotropy
            if (r_eig[S_D+2].qz) begin
                r_ta <= '0;
                r_tb <= '0;
            end else begin
                r_ta <= r_eig[S_D+2].sa ? -w_ta_m : w_ta_m;
                r_tb <= r_eig[S_D+2].sb ? -w_tb_m : w_tb_m;
            end
        end
    end

    // ---------------- angle ----------------
    logic signed [CW-1:0] r_cx [ANGLE_STEPS+1];
    logic signed [CW-1:0] r_cy [ANGLE_STEPS+1];
    logic signed [ZW-1:0] r_cz [ANGLE_STEPS+1];
    logic signed [CW-1:0] n_cx [ANGLE_STEPS+1];
    logic signed [CW-1:0] n_cy [ANGLE_STEPS+1];
    logic signed [ZW-1:0] n_cz [ANGLE_STEPS+1];
    logic signed [AW-1:0] r_ang [S_ANG:LAST-1];
    logic signed [AW-1:0] n_ang;
    logic signed [ZW:0]   w_th, w_rnd;

    always_comb begin : vectoring
        logic signed [CW-1:0] x0, y0, dx, dy;
        x0 = CW'(r_a0) <<< CORDIC_SHIFT;
        y0 = -(CW'(r_b0) <<< CORDIC_SHIFT);
        // fold the left half plane onto the right one
        if (x0 < 0) begin
            n_cz[0] = (y0 > 0) ? PI_Q30 : -PI_Q30;
            n_cx[0] = -x0;
            n_cy[0] = -y0;
        end else begin
            n_cz[0] = '0;
            n_cx[0] = x0;
            n_cy[0] = y0;
        end
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            dx = r_cy[i] >>> i;
            dy = r_cx[i] >>> i;
            if (!r_cy[i][CW-1]) begin
                n_cx[i+1] = r_cx[i] + dx;
                n_cy[i+1] = r_cy[i] - dy;
                n_cz[i+1] = r_cz[i] + atan_q30(5'(i));
            end else begin
                n_cx[i+1] = r_cx[i] - dx;
                n_cy[i+1] = r_cy[i] + dy;
                n_cz[i+1] = r_cz[i] - atan_q30(5'(i));
            end
        end
    end

    assign w_th  = (ZW+1)'(r_cz[ANGLE_STEPS] >>> 1) + (ZW+1)'(HALF_PI_Q30);
    assign w_rnd = (w_th + (ZW+1)'(8192)) >>> 14;

    always_comb begin
        if (w_rnd > (ZW+1)'(ANG_MAX)) begin
            n_ang = AW'(ANG_MAX);
        end else if (w_rnd < (ZW+1)'(ANG_MIN)) begin
            n_ang = AW'(ANG_MIN);
        end else begin
            n_ang = AW'(w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx         <= n_cx;
            r_cy         <= n_cy;
            r_cz         <= n_cz;
            r_ang[S_ANG] <= n_ang;
            for (int k = S_ANG + 1; k <= LAST - 1; k++) begin
                r_ang[k] <= r_ang[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [39:0] w_xx, w_xy, w_yy;

    assign w_xx = (40'(r_eig[LAST-1].sum) - 40'(r_ta) + 40'sd1) >>> 1;
    assign w_yy = (40'(r_eig[LAST-1].sum) + 40'(r_ta) + 40'sd1) >>> 1;
    assign w_xy = (40'(r_tb) + 40'sd1) >>> 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_eig_large  <= sat32(40'(r_eig[LAST-1].big));
            o_eig_small  <= sat32(40'(r_eig[LAST-1].small_v));
            o_axis_angle <= r_eig[LAST-1].qz ? '0 : r_ang[LAST-1];
            o_floored_xx <= sat32(w_xx);
            o_floored_xy <= sat32(w_xy);
            o_floored_yy <= sat32(w_yy);
        end
    end

    `CEF_ASSERT_NOW(a_stall_src, o_in_stall, o_out_valid && i_out_stall, "stall without held beat")
    `CEF_ASSERT_NEXT(a_freeze, o_in_stall, r_v == $past(r_v), "valid bits moved during stall")
    `CEF_ASSERT_NEXT(a_advance, !o_in_stall, o_out_valid == $past(r_v[LAST-1]), "beat lost in last stage")
    `CEF_ASSERT_NOW(a_order, o_out_valid, o_eig_large >= o_eig_small, "eigenvalues out of order")

endmodule
